FILE: sv/gaps_pkg.sv
package gaps_pkg;

    localparam int CW = 3;
    localparam int AW = 2 * CW;
    localparam int COST_W = 24;
    localparam int GF_W = 2 * COST_W;
    localparam int ROOT_W = 12;
    localparam logic [COST_W-1:0] COST_MAX = 24'hFFFFFF;

    typedef logic [CW-1:0] t_coord;
    typedef logic [AW-1:0] t_addr;
    typedef logic [COST_W-1:0] t_cost;

    typedef struct packed {
        logic accept;
        logic init;
        logic scan_clr;
        logic scan_issue;
        logic expand;
        logic load_g;
        logic nb_rd;
        logic nb_upd;
        logic walk_init;
        logic walk_push;
        logic walk_load;
        logic emit_rd;
        logic emit;
        logic err;
    } t_cmd;

    typedef struct packed {
        logic is_solve;
        logic start_out;
        logic cur_goal;
        logic scan_last;
        logic found;
        logic nb_valid;
        logic nb_last;
        logic nb_done;
        logic walk_stop;
        logic emit_last;
    } t_sts;

    // Rounded 256*sqrt(dx*dx+dy*dy) for offsets of up to seven cells.
    function automatic logic [ROOT_W-1:0] gaps_root(input t_coord dx, input t_coord dy);
        logic [6:0] d;
        logic [ROOT_W-1:0] r;
        d = 7'({4'b0, dx} * {4'b0, dx}) + 7'({4'b0, dy} * {4'b0, dy});
        case (d)
            7'd0: r = 12'd0;
            7'd1: r = 12'd256;
            7'd2: r = 12'd362;
            7'd4: r = 12'd512;
            7'd5: r = 12'd572;
            7'd8: r = 12'd724;
            7'd9: r = 12'd768;
            7'd10: r = 12'd810;
            7'd13: r = 12'd923;
            7'd16: r = 12'd1024;
            7'd17: r = 12'd1056;
            7'd18: r = 12'd1086;
            7'd20: r = 12'd1145;
            7'd25: r = 12'd1280;
            7'd26: r = 12'd1305;
            7'd29: r = 12'd1379;
            7'd32: r = 12'd1448;
            7'd34: r = 12'd1493;
            7'd36: r = 12'd1536;
            7'd37: r = 12'd1557;
            7'd40: r = 12'd1619;
            7'd41: r = 12'd1639;
            7'd45: r = 12'd1717;
            7'd49: r = 12'd1792;
            7'd50: r = 12'd1810;
            7'd52: r = 12'd1846;
            7'd53: r = 12'd1864;
            7'd58: r = 12'd1950;
            7'd61: r = 12'd1999;
            7'd65: r = 12'd2064;
            7'd72: r = 12'd2172;
            7'd74: r = 12'd2202;
            7'd85: r = 12'd2360;
            7'd98: r = 12'd2534;
            default: r = 12'd0;
        endcase
        return r;
    endfunction

endpackage

FILE: sv/gaps_ctrl.sv
module gaps_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  gaps_pkg::t_sts  i_sts,
    output gaps_pkg::t_cmd  o_cmd,
    output logic            o_busy
);
    import gaps_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_INIT   = 4'd1;
    localparam logic [3:0] S_SCAN0  = 4'd2;
    localparam logic [3:0] S_SCAN   = 4'd3;
    localparam logic [3:0] S_SCANE  = 4'd4;
    localparam logic [3:0] S_SDEC   = 4'd5;
    localparam logic [3:0] S_EXPG   = 4'd6;
    localparam logic [3:0] S_NBRD   = 4'd7;
    localparam logic [3:0] S_NBUPD  = 4'd8;
    localparam logic [3:0] S_WALK0  = 4'd9;
    localparam logic [3:0] S_WALKRD = 4'd10;
    localparam logic [3:0] S_WALKLD = 4'd11;
    localparam logic [3:0] S_EMRD   = 4'd12;
    localparam logic [3:0] S_EMOUT  = 4'd13;
    localparam logic [3:0] S_ERR    = 4'd14;

    logic [3:0] r_state, n_state;
    logic [3:0] s_after;

    assign s_after = i_sts.cur_goal ? S_WALK0 : S_SCAN0;
    assign o_busy  = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.accept = 1'b1;
                    if (i_sts.is_solve) begin
                        n_state = i_sts.start_out ? S_ERR : S_INIT;
                    end
                end
            end
            S_INIT: begin
                o_cmd.init = 1'b1;
                n_state = s_after;
            end
            S_SCAN0: begin
                o_cmd.scan_clr = 1'b1;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan_issue = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_SCANE;
                end
            end
            S_SCANE: n_state = S_SDEC;
            S_SDEC: begin
                if (i_sts.found) begin
                    o_cmd.expand = 1'b1;
                    n_state = S_EXPG;
                end else begin
                    n_state = S_WALK0;
                end
            end
            S_EXPG: begin
                o_cmd.load_g = 1'b1;
                n_state = S_NBRD;
            end
            S_NBRD: begin
                o_cmd.nb_rd = 1'b1;
                if (i_sts.nb_valid) begin
                    n_state = S_NBUPD;
                end else if (i_sts.nb_last) begin
                    n_state = s_after;
                end
            end
            S_NBUPD: begin
                o_cmd.nb_upd = 1'b1;
                n_state = i_sts.nb_done ? s_after : S_NBRD;
            end
            S_WALK0: begin
                o_cmd.walk_init = 1'b1;
                n_state = S_WALKRD;
            end
            S_WALKRD: begin
                o_cmd.walk_push = 1'b1;
                n_state = i_sts.walk_stop ? S_EMRD : S_WALKLD;
            end
            S_WALKLD: begin
                o_cmd.walk_load = 1'b1;
                n_state = S_WALKRD;
            end
            S_EMRD: begin
                o_cmd.emit_rd = 1'b1;
                n_state = S_EMOUT;
            end
            S_EMOUT: begin
                o_cmd.emit = 1'b1;
                n_state = i_sts.emit_last ? S_IDLE : S_EMRD;
            end
            S_ERR: begin
                o_cmd.err = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: sv/gaps_dp.sv
module gaps_dp #(
    parameter int MAP_WIDTH  = 8,
    parameter int MAP_HEIGHT = 8,
    parameter int NODE_SIZE  = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  gaps_pkg::t_cmd   i_cmd,
    output gaps_pkg::t_sts   o_sts,
    input  logic             i_command,
    input  logic [2:0]       i_cell_x,
    input  logic [2:0]       i_cell_y,
    input  logic             i_blocked,
    input  logic [9:0]       i_pos_x,
    input  logic [9:0]       i_pos_y,
    output logic             o_strobe,
    output logic [7:0]       o_point_x,
    output logic [7:0]       o_point_y,
    output logic             o_status,
    output logic             o_last
);
    import gaps_pkg::*;

    localparam int CELLS = 1 << AW;
    localparam t_coord GX = t_coord'(MAP_WIDTH - 1);
    localparam t_coord GY = t_coord'(MAP_HEIGHT - 1);
    localparam logic [10:0] XLIM = 11'(MAP_WIDTH * NODE_SIZE);
    localparam logic [10:0] YLIM = 11'(MAP_HEIGHT * NODE_SIZE);
    localparam logic [3:0] WEXT = 4'(MAP_WIDTH);
    localparam logic [3:0] HEXT = 4'(MAP_HEIGHT);
    localparam t_cost NS24 = t_cost'(NODE_SIZE);
    localparam logic [8:0] NS9 = 9'(NODE_SIZE);
    localparam logic [8:0] HALF = 9'(NODE_SIZE / 2);

    logic [CELLS-1:0] r_obst, r_vis, r_que, r_rch, r_pv;
    logic [GF_W-1:0] mem_gf [CELLS];
    logic [AW-1:0]   mem_par [CELLS];
    logic [AW-1:0]   mem_chain [CELLS];
    logic [GF_W-1:0] r_gf_q;
    t_addr r_par_q, r_chain_q;

    t_coord r_cx, r_cy, r_bx, r_by, r_scx, r_scy, r_nx, r_ny, r_wx, r_wy;
    t_cost  r_bf, r_gcur, r_step, r_h;
    logic   r_found, r_sv, r_nb_last;
    t_addr  r_sa, r_ei;
    logic [1:0] r_ox, r_oy;
    logic [AW:0] r_len;

    logic r_vld, r_o_status, r_o_last;
    logic [7:0] r_o_x, r_o_y;

    t_coord s_sx, s_sy;
    always_comb begin
        s_sx = '0;
        s_sy = '0;
        for (int k = 1; k < MAP_WIDTH; k++) begin
            if ({1'b0, i_pos_x} >= 11'(k * NODE_SIZE)) s_sx = s_sx + 3'd1;
        end
        for (int k = 1; k < MAP_HEIGHT; k++) begin
            if ({1'b0, i_pos_y} >= 11'(k * NODE_SIZE)) s_sy = s_sy + 3'd1;
        end
    end

    t_cost s_hstart;
    assign s_hstart = t_cost'(gaps_root(GX - r_cx, GY - r_cy)) * NS24;

    t_cost s_fval;
    logic  s_cand, s_better;
    assign s_fval   = r_rch[r_sa] ? r_gf_q[COST_W-1:0] : COST_MAX;
    assign s_cand   = r_sv && r_que[r_sa] && !r_vis[r_sa];
    assign s_better = s_cand && (!r_found || s_fval < r_bf);

    logic [3:0] s_xe, s_ye;
    t_coord s_nx, s_ny;
    t_addr  s_na;
    logic   s_nvalid;
    assign s_xe = {1'b0, r_cx} + {2'b0, r_ox};
    assign s_ye = {1'b0, r_cy} + {2'b0, r_oy};
    assign s_nx = t_coord'(s_xe - 4'd1);
    assign s_ny = t_coord'(s_ye - 4'd1);
    assign s_na = {s_ny, s_nx};
    assign s_nvalid = !(r_ox == 2'd1 && r_oy == 2'd1) && s_xe != 4'd0 && s_ye != 4'd0
                      && s_xe <= WEXT && s_ye <= HEXT;

    t_coord s_dx, s_dy;
    assign s_dx = (r_ox == 2'd1) ? 3'd0 : 3'd1;
    assign s_dy = (r_oy == 2'd1) ? 3'd0 : 3'd1;

    t_addr s_nadr;
    logic [COST_W:0] s_csum, s_fsum;
    t_cost s_cand_g, s_gn, s_fnew;
    logic  s_upd;
    assign s_nadr   = {r_ny, r_nx};
    assign s_csum   = {1'b0, r_gcur} + {1'b0, r_step};
    assign s_cand_g = s_csum[COST_W] ? COST_MAX : s_csum[COST_W-1:0];
    assign s_gn     = r_rch[s_nadr] ? r_gf_q[GF_W-1:COST_W] : COST_MAX;
    assign s_fsum   = {1'b0, s_cand_g} + {1'b0, r_h};
    assign s_fnew   = s_fsum[COST_W] ? COST_MAX : s_fsum[COST_W-1:0];
    assign s_upd    = s_cand_g < s_gn;

    logic        s_we, s_re;
    t_addr       s_wa, s_ra;
    logic [GF_W-1:0] s_wd;
    always_comb begin
        s_we = 1'b0;
        s_wa = {r_cy, r_cx};
        s_wd = {t_cost'(0), s_hstart};
        if (i_cmd.nb_upd && s_upd) begin
            s_we = 1'b1;
            s_wa = s_nadr;
            s_wd = {s_cand_g, s_fnew};
        end else if (i_cmd.init) begin
            s_we = 1'b1;
        end
        s_re = i_cmd.scan_issue || i_cmd.expand || (i_cmd.nb_rd && s_nvalid);
        if (i_cmd.scan_issue) begin
            s_ra = {r_scy, r_scx};
        end else if (i_cmd.expand) begin
            s_ra = {r_by, r_bx};
        end else begin
            s_ra = s_na;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_we) mem_gf[s_wa] <= s_wd;
        if (s_re) r_gf_q <= mem_gf[s_ra];
        if (i_cmd.nb_upd && s_upd) mem_par[s_nadr] <= {r_cy, r_cx};
        if (i_cmd.walk_push) begin
            r_par_q <= mem_par[{r_wy, r_wx}];
            mem_chain[r_len[AW-1:0]] <= {r_wy, r_wx};
        end
        if (i_cmd.emit_rd) r_chain_q <= mem_chain[r_ei];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_obst <= '0;
            r_vis <= '0;
            r_que <= '0;
            r_rch <= '0;
            r_pv <= '0;
            r_found <= 1'b0;
            r_sv <= 1'b0;
            r_vld <= 1'b0;
        end else begin
            r_sv <= i_cmd.scan_issue;
            r_vld <= i_cmd.emit || i_cmd.err;
            if (i_cmd.accept) begin
                if (!i_command) begin
                    if ({1'b0, i_cell_x} < WEXT && {1'b0, i_cell_y} < HEXT) begin
                        r_obst[{i_cell_y, i_cell_x}] <= i_blocked;
                    end
                end else begin
                    r_cx <= s_sx;
                    r_cy <= s_sy;
                end
            end
            if (i_cmd.init) begin
                r_vis <= '0;
                r_pv <= '0;
                r_que <= CELLS'(1) << {r_cy, r_cx};
                r_rch <= CELLS'(1) << {r_cy, r_cx};
            end
            if (i_cmd.scan_clr) begin
                r_found <= 1'b0;
                r_scx <= '0;
                r_scy <= '0;
            end
            if (i_cmd.scan_issue) begin
                r_sa <= {r_scy, r_scx};
                if (r_scx == GX) begin
                    r_scx <= '0;
                    r_scy <= r_scy + 3'd1;
                end else begin
                    r_scx <= r_scx + 3'd1;
                end
            end
            if (s_better) begin
                r_found <= 1'b1;
                r_bf <= s_fval;
                r_bx <= r_sa[CW-1:0];
                r_by <= r_sa[AW-1:CW];
            end
            if (i_cmd.expand) begin
                r_cx <= r_bx;
                r_cy <= r_by;
                r_vis[{r_by, r_bx}] <= 1'b1;
            end
            if (i_cmd.load_g) begin
                r_gcur <= r_rch[{r_cy, r_cx}] ? r_gf_q[GF_W-1:COST_W] : COST_MAX;
                r_ox <= 2'd0;
                r_oy <= 2'd0;
            end
            if (i_cmd.nb_rd) begin
                r_nb_last <= (r_ox == 2'd2 && r_oy == 2'd2);
                if (r_ox == 2'd2) begin
                    r_ox <= 2'd0;
                    r_oy <= r_oy + 2'd1;
                end else begin
                    r_ox <= r_ox + 2'd1;
                end
                if (s_nvalid) begin
                    r_nx <= s_nx;
                    r_ny <= s_ny;
                    r_step <= t_cost'(gaps_root(s_dx, s_dy)) * NS24;
                    r_h <= t_cost'(gaps_root(GX - s_nx, GY - s_ny)) * NS24;
                    if (!r_vis[s_na] && !r_obst[s_na]) r_que[s_na] <= 1'b1;
                end
            end
            if (i_cmd.nb_upd && s_upd) begin
                r_pv[s_nadr] <= 1'b1;
                r_rch[s_nadr] <= 1'b1;
            end
            if (i_cmd.walk_init) begin
                r_wx <= GX;
                r_wy <= GY;
                r_len <= '0;
            end
            if (i_cmd.walk_push) begin
                r_ei <= r_len[AW-1:0];
                r_len <= r_len + 7'd1;
            end
            if (i_cmd.walk_load) begin
                r_wx <= r_par_q[CW-1:0];
                r_wy <= r_par_q[AW-1:CW];
            end
            if (i_cmd.emit) begin
                r_ei <= r_ei - 6'd1;
            end
        end
    end

    logic [8:0] s_ptx, s_pty;
    assign s_ptx = 9'(r_chain_q[CW-1:0]) * NS9 + HALF;
    assign s_pty = 9'(r_chain_q[AW-1:CW]) * NS9 + HALF;

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_x <= s_ptx[7:0];
            r_o_y <= s_pty[7:0];
            r_o_status <= 1'b0;
            r_o_last <= (r_ei == '0);
        end else if (i_cmd.err) begin
            r_o_x <= '0;
            r_o_y <= '0;
            r_o_status <= 1'b1;
            r_o_last <= 1'b1;
        end
    end

    assign o_strobe  = r_vld;
    assign o_point_x = r_o_x;
    assign o_point_y = r_o_y;
    assign o_status  = r_o_status;
    assign o_last    = r_o_last;

    assign o_sts.is_solve  = i_command;
    assign o_sts.start_out = ({1'b0, i_pos_x} >= XLIM) || ({1'b0, i_pos_y} >= YLIM);
    assign o_sts.cur_goal  = (r_cx == GX) && (r_cy == GY);
    assign o_sts.scan_last = (r_scx == GX) && (r_scy == GY);
    assign o_sts.found     = r_found;
    assign o_sts.nb_valid  = s_nvalid;
    assign o_sts.nb_last   = (r_ox == 2'd2) && (r_oy == 2'd2);
    assign o_sts.nb_done   = r_nb_last;
    assign o_sts.walk_stop = !r_pv[{r_wy, r_wx}] || (r_len == 7'(CELLS - 1));
    assign o_sts.emit_last = (r_ei == '0);

endmodule

FILE: sv/grid_astar_path_search_unit.sv
// A write never raises busy; an out-of-map solve strobes a single error word.
// A solve strobes one word per path cell, the last after all expansions with their neighbour updates,
// the walk back along the path and, when the goal is never expanded, one more scan.
// Each expansion is bound by a scan of every map cell in the cost memory for the least f.
// One item at a time; busy falls in the cycle of the last result word, which cannot stall.
// Synchronous active-low reset clears the obstacle map and all control state.
module grid_astar_path_search_unit #(
    parameter int MAP_WIDTH  = 8,
    parameter int MAP_HEIGHT = 8,
    parameter int NODE_SIZE  = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic       i_command,
    input  logic [2:0] i_cell_x,
    input  logic [2:0] i_cell_y,
    input  logic       i_blocked,
    input  logic [9:0] i_pos_x,
    input  logic [9:0] i_pos_y,
    output logic       o_strobe,
    output logic [7:0] o_point_x,
    output logic [7:0] o_point_y,
    output logic       o_status,
    output logic       o_last
);
    import gaps_pkg::*;

    t_cmd cmd;
    t_sts sts;

    gaps_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    gaps_dp #(
        .MAP_WIDTH  (MAP_WIDTH),
        .MAP_HEIGHT (MAP_HEIGHT),
        .NODE_SIZE  (NODE_SIZE)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .o_sts     (sts),
        .i_command (i_command),
        .i_cell_x  (i_cell_x),
        .i_cell_y  (i_cell_y),
        .i_blocked (i_blocked),
        .i_pos_x   (i_pos_x),
        .i_pos_y   (i_pos_y),
        .o_strobe  (o_strobe),
        .o_point_x (o_point_x),
        .o_point_y (o_point_y),
        .o_status  (o_status),
        .o_last    (o_last)
    );

endmodule

FILE: sv/gaps_chk.sv
module gaps_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       i_command,
    input logic       o_strobe,
    input logic [7:0] o_point_x,
    input logic [7:0] o_point_y,
    input logic       o_status,
    input logic       o_last
);

    a_more_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last |=> busy)
        else $error("Busy dropped before the last result word.");

    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && !i_command |=> !o_strobe && !busy)
        else $error("An obstacle write produced a result word.");

    a_solve_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_command |=> busy)
        else $error("A solve did not raise busy.");

    a_err_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_status |-> o_last && o_point_x == 8'd0 && o_point_y == 8'd0)
        else $error("An error word is malformed.");

endmodule

bind grid_astar_path_search_unit gaps_chk u_gaps_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .start     (start),
    .busy      (busy),
    .i_command (i_command),
    .o_strobe  (o_strobe),
    .o_point_x (o_point_x),
    .o_point_y (o_point_y),
    .o_status  (o_status),
    .o_last    (o_last)
);
